// File: sv/hex2b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex-to-base64 package
// Shared types, constants and character functions of the hex-to-base64 block.
// ----------------------------------------------------------------------------
package hex2b64_pkg;

  // Result status codes.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatBadDigit = 2'd1;
  localparam logic [1:0] StatOddCount = 2'd2;

  // Padding character '='.
  localparam logic [7:0] PadChar = 8'h3D;

  // Largest number of results that one digit can cause.
  localparam int MaxResults = 4;

  // One group of results, written to the queue for one accepted digit.
  typedef struct packed {
    logic [2:0]                      cnt;     // results in the group, 1 to 4
    logic [MaxResults-1:0][7:0]      chars;   // characters, slot 0 first
    logic [1:0]                      status;  // status for every result
    logic                            closes;  // last result ends the string
  } entry_t;

  // Push request from the front to the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Decodes an ASCII hex digit. Bit 4 is set when the code is not a digit.
  function automatic logic [4:0] decode_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b0, 4'(c - 8'h37)};
    end
    return res;
  endfunction

  // Maps a 6-bit value to its standard base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] res;
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      res = 8'h41 + wide;
    end else if (idx < 6'd52) begin
      res = 8'h61 + wide - 8'd26;
    end else if (idx < 6'd62) begin
      res = 8'h30 + wide - 8'd52;
    end else if (idx == 6'd62) begin
      res = 8'h2B;
    end else begin
      res = 8'h2F;
    end
    return res;
  endfunction

endpackage

// File: sv/hex2b64_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex digit channel
// Valid/ready channel that carries one ASCII hex digit and its end flag.
// ----------------------------------------------------------------------------
interface hex2b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       last;

  modport source (output valid, output hex_char, output last, input ready);
  modport sink   (input valid, input hex_char, input last, output ready);
endinterface

// File: sv/hex2b64_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 character channel
// Valid/ready channel that carries one base64 character with flag and status.
// ----------------------------------------------------------------------------
interface hex2b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input status,
                  output ready);
endinterface

// File: sv/hex2b64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex-to-base64 front end
// Accepts digits, pairs them into bytes, packs bits and builds result groups.
// ----------------------------------------------------------------------------
module hex2b64_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  hex2b64_in_if.sink          in_i,
  input  logic                full_i,
  output hex2b64_pkg::push_t  push_o
);
  import hex2b64_pkg::*;

  logic [3:0]  held_nibble_q, held_nibble_d;
  logic        nibble_waiting_q, nibble_waiting_d;
  logic [11:0] bit_buffer_q, bit_buffer_d;
  logic [1:0]  bit_pairs_q, bit_pairs_d;       // bits held, in units of two
  logic [1:0]  chars_mod_four_q, chars_mod_four_d;
  logic        dropping_q, dropping_d;

  logic        accept;
  logic [4:0]  digit;
  logic [11:0] nb;
  logic [5:0]  c0, c1;
  logic [1:0]  left_pairs;
  logic [2:0]  n_data;
  logic [1:0]  cmf_after;
  logic [1:0]  pads;
  entry_t      entry;
  logic        push;

  // A digit is taken whenever the queue has room for its group.
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign digit      = decode_digit(in_i.hex_char);
  assign nb         = {bit_buffer_q[3:0], held_nibble_q, digit[3:0]};

  // Characters that the completed byte releases.
  always_comb begin
    c0         = nb[7:2];
    c1         = 6'd0;
    left_pairs = 2'd1;
    n_data     = 3'd1;
    case (bit_pairs_q)
      2'd1: begin
        c0         = nb[9:4];
        left_pairs = 2'd2;
      end
      2'd2: begin
        c0         = nb[11:6];
        c1         = nb[5:0];
        left_pairs = 2'd0;
        n_data     = 3'd2;
      end
      default: begin
        c0         = nb[7:2];
        left_pairs = 2'd1;
      end
    endcase
    // On the final digit, leftover bits go out padded with zeros on the right.
    if (in_i.last && left_pairs != 2'd0) begin
      c1     = (left_pairs == 2'd1) ? {nb[1:0], 4'b0000} : {nb[3:0], 2'b00};
      n_data = 3'd2;
    end
    cmf_after = chars_mod_four_q + n_data[1:0];
    pads      = in_i.last ? (2'd0 - cmf_after) : 2'd0;
  end

  // Classification and state update for one digit.
  always_comb begin
    held_nibble_d    = held_nibble_q;
    nibble_waiting_d = nibble_waiting_q;
    bit_buffer_d     = bit_buffer_q;
    bit_pairs_d      = bit_pairs_q;
    chars_mod_four_d = chars_mod_four_q;
    dropping_d       = dropping_q;
    push             = 1'b0;
    entry.cnt        = 3'd1;
    entry.chars      = '0;
    entry.status     = StatOk;
    entry.closes     = 1'b1;

    if (accept) begin
      if (dropping_q) begin
        // Discard the rest of a failed string.
        if (in_i.last) begin
          dropping_d = 1'b0;
        end
      end else if (in_i.last && !nibble_waiting_q) begin
        // Odd digit count at the end of the string.
        push             = 1'b1;
        entry.status     = StatOddCount;
        held_nibble_d    = '0;
        nibble_waiting_d = 1'b0;
        bit_buffer_d     = '0;
        bit_pairs_d      = '0;
        chars_mod_four_d = '0;
      end else if (digit[4]) begin
        // Invalid digit; drop the rest unless this was the final item.
        push             = 1'b1;
        entry.status     = StatBadDigit;
        held_nibble_d    = '0;
        nibble_waiting_d = 1'b0;
        bit_buffer_d     = '0;
        bit_pairs_d      = '0;
        chars_mod_four_d = '0;
        dropping_d       = !in_i.last;
      end else if (!nibble_waiting_q) begin
        // High nibble of a byte.
        held_nibble_d    = digit[3:0];
        nibble_waiting_d = 1'b1;
      end else begin
        // Low nibble completes a byte.
        push         = 1'b1;
        entry.cnt    = n_data + {1'b0, pads};
        entry.closes = in_i.last;
        for (int i = 0; i < MaxResults; i++) begin
          entry.chars[i] = PadChar;
        end
        entry.chars[0] = b64_char(c0);
        if (n_data == 3'd2) begin
          entry.chars[1] = b64_char(c1);
        end
        if (in_i.last) begin
          held_nibble_d    = '0;
          nibble_waiting_d = 1'b0;
          bit_buffer_d     = '0;
          bit_pairs_d      = '0;
          chars_mod_four_d = '0;
        end else begin
          held_nibble_d    = '0;
          nibble_waiting_d = 1'b0;
          bit_buffer_d     = nb;
          bit_pairs_d      = left_pairs;
          chars_mod_four_d = cmf_after;
        end
      end
    end
  end

  assign push_o.valid = push;
  assign push_o.entry = entry;

  // Encoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_nibble_q    <= '0;
      nibble_waiting_q <= 1'b0;
      bit_buffer_q     <= '0;
      bit_pairs_q      <= '0;
      chars_mod_four_q <= '0;
      dropping_q       <= 1'b0;
    end else begin
      held_nibble_q    <= held_nibble_d;
      nibble_waiting_q <= nibble_waiting_d;
      bit_buffer_q     <= bit_buffer_d;
      bit_pairs_q      <= bit_pairs_d;
      chars_mod_four_q <= chars_mod_four_d;
      dropping_q       <= dropping_d;
    end
  end

endmodule

// File: sv/hex2b64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex-to-base64 group queue
// Small first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module hex2b64_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hex2b64_pkg::push_t  push_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output hex2b64_pkg::entry_t head_o
);
  import hex2b64_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update, with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Group storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// File: sv/hex2b64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex-to-base64 back end
// Takes result groups from the queue and sends them one character per beat.
// ----------------------------------------------------------------------------
module hex2b64_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  hex2b64_pkg::entry_t head_i,
  output logic                pop_o,
  hex2b64_out_if.source       out_o
);
  import hex2b64_pkg::*;

  logic       busy_q, busy_d;
  entry_t     cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       last_slot;
  logic       done;

  // Output beat comes straight from the held group.
  assign last_slot      = ({1'b0, idx_q} == cur_q.cnt - 3'd1);
  assign out_o.valid    = busy_q;
  assign out_o.out_char = cur_q.chars[idx_q];
  assign out_o.out_last = cur_q.closes && last_slot;
  assign out_o.status   = cur_q.status;

  // Load the next group as the current one finishes, with no gap.
  assign done  = busy_q && out_o.ready && last_slot;
  assign pop_o = !empty_i && (!busy_q || done);

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      cur_d  = head_i;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && out_o.ready) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Group payload needs no reset.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// File: sv/hex_text_to_base64_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex text to base64 encoder
// Converts a stream of ASCII hex digits into standard base64 characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one ASCII hex digit per beat; last marks the final digit of a
//   string. out_o gives one character per beat with out_last on the final
//   character of a string and a status code; an error beat carries char 0.
//   A digit is accepted in every cycle while the group queue has room, so a
//   string streams at one digit per cycle. Each completed byte or error puts
//   a group of one to four characters into a queue of QueueDepth groups; the
//   back end sends one character per cycle while the receiver is ready, so
//   the end-of-string burst of up to four characters is absorbed by the queue.
//   An accepted digit's group is written into the queue and then loaded into
//   the back end's held group, which offers its first character.
//   When the receiver stalls, the current character holds and the queue
//   fills; in_i.ready drops only when the queue is full.
//   Reset clears the encoder state, empties the queue and drops out_o.valid.
// ----------------------------------------------------------------------------
module hex_text_to_base64_encoder_unit #(
  parameter int QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hex2b64_in_if.sink    in_i,
  hex2b64_out_if.source out_o
);
  import hex2b64_pkg::*;

  push_t  push;
  entry_t head;
  logic   full;
  logic   empty;
  logic   pop;

  // Digit intake and classification.
  hex2b64_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  // Queue of result groups.
  hex2b64_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Character output.
  hex2b64_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: sv/hex2b64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex-to-base64 port checker
// Checks output beats of the encoder as seen on its ports.
// ----------------------------------------------------------------------------
module hex2b64_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i,
  input logic [1:0] status_i
);
  import hex2b64_pkg::*;

  // A stalled beat stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat withdrawn while stalled");

  // A stalled beat keeps its payload.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_char_i) && $stable(out_last_i) && $stable(status_i))
    else $error("output payload changed while stalled");

  // An error beat always closes the string and carries no character.
  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != StatOk |-> out_last_i && out_char_i == 8'h00)
    else $error("error beat without end flag or with a character");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      status_i == StatOk || status_i == StatBadDigit || status_i == StatOddCount)
    else $error("undefined status code");

endmodule

bind hex_text_to_base64_encoder_unit hex2b64_checker u_hex2b64_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.out_last),
  .status_i    (out_o.status)
);

// File: sim/hex_text_to_base64_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex text to base64 encoder testbench
// Sends strings of ASCII hex digits, some clean and some broken by bad digits,
// odd digit counts or random noise. Each accepted digit runs through a
// behavioral encoder in a scoreboard. Every output beat is compared against
// the oldest predicted character, end flag and status. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module hex_text_to_base64_encoder_unit_tb;
  import hex2b64_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomDigits = 100;

  // One predicted output beat.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] status;
  } b64_beat_t;

  // Behavioral encoder and the queue of characters it predicts.
  class b64_scoreboard;
    b64_beat_t  pending_beats[$];
    logic [3:0]  held_nib;
    logic        nib_waiting;
    logic [11:0] bit_buf;
    logic [3:0]  bits_left;
    logic [1:0]  char_phase;
    logic        discarding;
    int          mismatches;
    int          beats_checked;
    int          error_beats;

    function new();
      clear();
      mismatches    = 0;
      beats_checked = 0;
      error_beats   = 0;
    endfunction

    function void clear();
      held_nib    = '0;
      nib_waiting = 1'b0;
      bit_buf     = '0;
      bits_left   = '0;
      char_phase  = '0;
      discarding  = 1'b0;
    endfunction

    // Nibble value of a hex digit; bit 4 is set for any other code.
    static function logic [4:0] nibble_of(logic [7:0] c);
      logic [7:0] folded;
      logic [4:0] v;
      folded = c | 8'h20;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 5'(c - 8'h30);
      end else if (folded >= 8'h61 && folded <= 8'h66) begin
        v = 5'(folded - 8'h57);
      end
      return v;
    endfunction

    function logic [7:0] b64_symbol(logic [5:0] idx);
      string alpha;
      alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return 8'(alpha[idx]);
    endfunction

    function void push(logic [7:0] c, logic lst, logic [1:0] st);
      b64_beat_t beat;
      beat.out_char = c;
      beat.out_last = lst;
      beat.status   = st;
      pending_beats = {pending_beats, beat};
    endfunction

    // Predicts the beats of one accepted digit. Returns 0 when the digit is
    // discarded after an earlier error.
    function bit note_digit(logic [7:0] c, logic lst);
      logic [4:0] nib;
      logic [5:0] idx;
      if (discarding) begin
        if (lst) clear();
        return 1'b0;
      end
      // A final digit with no partner is an odd count, even if it is bad too.
      if (lst && !nib_waiting) begin
        push(8'h00, 1'b1, StatOddCount);
        clear();
        return 1'b1;
      end
      nib = nibble_of(c);
      if (nib[4]) begin
        push(8'h00, 1'b1, StatBadDigit);
        clear();
        discarding = !lst;
        return 1'b1;
      end
      if (!nib_waiting) begin
        held_nib    = nib[3:0];
        nib_waiting = 1'b1;
        return 1'b1;
      end
      // A byte is complete: pack it and give out every full sextet.
      nib_waiting = 1'b0;
      bit_buf     = {bit_buf[3:0], held_nib, nib[3:0]};
      held_nib    = '0;
      bits_left   = {1'b0, bits_left[2:0]} + 4'd8;
      while (bits_left >= 4'd6) begin
        idx = 6'(bit_buf >> (bits_left - 4'd6));
        push(b64_symbol(idx), 1'b0, StatOk);
        char_phase++;
        bits_left -= 4'd6;
      end
      // End of string: flush leftover bits, then pad to a multiple of four.
      if (lst) begin
        if (bits_left != 0) begin
          idx = 6'(bit_buf << (4'd6 - bits_left));
          push(b64_symbol(idx), 1'b0, StatOk);
          char_phase++;
        end
        while (char_phase != 0) begin
          push(PadChar, 1'b0, StatOk);
          char_phase++;
        end
        pending_beats[pending_beats.size() - 1].out_last = 1'b1;
        clear();
      end
      return 1'b1;
    endfunction

    // Compares one output beat with the oldest prediction.
    function void check_char(logic [7:0] c, logic lst, logic [1:0] st);
      b64_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("Unexpected beat: out_char 0x%02h out_last %0b status %0d", c, lst, st);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (st != StatOk) error_beats++;
      if (want.out_char !== c) begin
        $error("out_char mismatch: expected 0x%02h, actual 0x%02h", want.out_char, c);
        mismatches++;
      end
      if (want.out_last !== lst) begin
        $error("out_last mismatch: expected %0b, actual %0b", want.out_last, lst);
        mismatches++;
      end
      if (want.status !== st) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  int   digits_sent;
  int   strings_sent;
  bit   no_idle;

  b64_scoreboard sb;

  hex2b64_in_if  in_if ();
  hex2b64_out_if out_if ();

  hex_text_to_base64_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a 20 ns period.
  always #10 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one digit after a random gap and returns once the beat is taken.
  task automatic send_digit(input logic [7:0] c, input logic lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.hex_char <= c;
    in_if.last     <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    if (sb.note_digit(c, lst)) digits_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_digit(8'(s[i]), i == s.len() - 1);
    end
    strings_sent++;
  endtask

  // Drops valid and holds until every predicted beat has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
  endtask

  // One random string: mostly clean, sometimes odd, bad or pure noise.
  task automatic send_random_string();
    string      digits;
    int         nbytes;
    int         ndig;
    int         kind;
    int         bad_pos;
    int         i;
    logic [7:0] c;
    logic [4:0] nib;
    digits  = "0123456789abcdefABCDEF";
    no_idle = ($urandom_range(0, 3) == 0);
    nbytes  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    ndig    = 2 * nbytes;
    kind    = $urandom_range(0, 9);
    if (kind == 0) ndig = ndig - 1;
    if (kind == 2) ndig = $urandom_range(1, 6);
    bad_pos = (kind == 1) ? $urandom_range(0, ndig - 1) : -1;
    for (i = 0; i < ndig; i++) begin
      if (kind == 2) begin
        c = 8'($urandom_range(0, 255));
      end else if (i == bad_pos) begin
        do begin
          c   = 8'($urandom_range(0, 255));
          nib = b64_scoreboard::nibble_of(c);
        end while (!nib[4]);
      end else begin
        c = 8'(digits[$urandom_range(0, 21)]);
      end
      send_digit(c, i == ndig - 1);
    end
    strings_sent++;
  endtask

  // Receiver: random stalls, and every taken beat goes to the scoreboard.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_char(out_if.out_char, out_if.out_last, out_if.status);
    end
  end

  // Stimulus and end of run.
  initial begin
    int random_start;
    bit paused;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.hex_char = 8'h00;
    in_if.last     = 1'b0;
    cycle_count    = 0;
    digits_sent    = 0;
    strings_sent   = 0;
    no_idle        = 1'b0;
    paused         = 1'b0;
    sb             = new();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed strings: one, two and three bytes, so two, one and no pads.
    send_text("4d");
    send_text("4d61");
    send_text("4D616E");
    // A lone final digit is an odd count.
    send_text("f");
    // Bad digit mid-string, then the rest is discarded up to the end flag.
    send_text("9A:0F");
    // Bad code on a final digit with no partner still reports an odd count.
    send_text("@");
    // Bad code on a final digit that completes a pair.
    send_text("0/");
    // Bad letter just past the hex range, then discard.
    send_text("Gf");
    // Codes with every bit high and every bit low.
    send_digit(8'hFF, 1'b0);
    send_digit(8'h00, 1'b1);
    strings_sent++;
    hold_until_drained();

    // Random strings, with one full drain halfway through.
    random_start = digits_sent;
    while (digits_sent - random_start < RandomDigits) begin
      send_random_string();
      if (!paused && digits_sent - random_start >= RandomDigits / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d digits in %0d strings; %0d beats checked, %0d of them errors.",
             digits_sent, strings_sent, sb.beats_checked, sb.error_beats);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
